// ===== rtl/brhs_pkg.sv =====
// Package: request and result types and status codes of the bucketed route hash store.
package brhs_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_BETTER    = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_NOTFOUND  = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  bucket_index;
        logic [9:0]  entry_tag;
        logic [31:0] entry_cost;
    } brhs_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] unique_count;
    } brhs_rsp_t;

endpackage

// ===== rtl/brhs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module brhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/bucketed_route_hash_store_core.sv =====
// Top level: bucketed hash store with tag compare, fill counts and entry memories.
//
// Requests enter on req / req_valid / req_stall, results leave on rsp / rsp_valid /
// rsp_stall. One request is worked at a time. When BUCKETS is not a power of two and
// is under 1024, the bucket index of an add or remove is first reduced by one compare
// and subtract a cycle. The fill count of the bucket is then read from a memory, and
// entries are read from the tag and cost memories one at a time, each in the steps
// read, wait, compare or write. An invalid request has its result in the cycle after
// it is taken. A clear request is a sweep over the fill memory, with its result when
// the sweep ends. After reset the fill memory is swept to zero, during which no
// request is taken; cost_epsilon_we writes are taken at any time. The result is held
// in an output register; while rsp_stall is high it holds and no new request is taken.
module bucketed_route_hash_store_core
    import brhs_pkg::*;
#(
    parameter int BUCKETS   = 1024,
    parameter int ENTRIES   = 8,
    parameter int COST_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cost_epsilon_we,
    input  logic [15:0] cost_epsilon_wdata,
    input  brhs_req_t   req,
    input  logic        req_valid,
    output logic        req_stall,
    output brhs_rsp_t   rsp,
    output logic        rsp_valid,
    input  logic        rsp_stall
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int AW = BW + EW;
    localparam int SLOTS = BUCKETS * (1 << EW);
    localparam bit BPOW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam int RSTEPS = (BPOW2 || BUCKETS > 1023) ? 0 : $clog2(1023 / BUCKETS + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_REDUCE, S_FREAD, S_FWAIT, S_SCAN, S_SWAIT, S_CMP,
        S_APPEND, S_SHIFT, S_SHWAIT, S_SHWR, S_DONE, S_CLEAR
    } state_t;

    state_t state_reg;
    logic [15:0] eps_reg;
    logic [13:0] total_reg;
    logic [BW-1:0] bkt_reg;
    logic [9:0] tag_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [1:0] type_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] idx_reg;
    logic better_reg, dup_reg;
    brhs_rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic [9:0] rem_reg;
    logic [3:0] step_reg;

    logic f_we, t_we, c_we;
    logic [BW-1:0] f_waddr, f_raddr;
    logic [FW-1:0] f_wdata, f_rdata;
    logic [AW-1:0] e_waddr, e_raddr;
    logic [9:0] t_wdata, t_rdata;
    logic [COST_BITS-1:0] c_wdata, c_rdata;

    brhs_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill (
        .clk(clk), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
        .rd_addr(f_raddr), .rd_data(f_rdata)
    );
    brhs_ram #(.WIDTH(10), .DEPTH(SLOTS)) u_tag (
        .clk(clk), .wr_en(t_we), .wr_addr(e_waddr), .wr_data(t_wdata),
        .rd_addr(e_raddr), .rd_data(t_rdata)
    );
    brhs_ram #(.WIDTH(COST_BITS), .DEPTH(SLOTS)) u_cost (
        .clk(clk), .wr_en(c_we), .wr_addr(e_waddr), .wr_data(c_wdata),
        .rd_addr(e_raddr), .rd_data(c_rdata)
    );

    logic accept;
    logic [BW-1:0] req_bkt;
    logic [COST_BITS-1:0] req_cost;
    logic is_better;
    logic [COST_BITS-1:0] cost_diff;
    logic [31:0] red_lim;
    logic red_ge;
    logic [9:0] rem_sub;

    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign req_bkt   = BW'(req.bucket_index);
    assign req_cost  = COST_BITS'({32'd0, req.entry_cost});
    assign cost_diff = c_rdata - cost_reg;
    assign is_better = (cost_reg < c_rdata)
                       && (cost_diff > COST_BITS'({48'd0, eps_reg}));
    assign red_lim   = 32'(BUCKETS) << step_reg;
    assign red_ge    = ({22'd0, rem_reg} >= red_lim);
    assign rem_sub   = red_ge ? (rem_reg - red_lim[9:0]) : rem_reg;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = bkt_reg;
        f_wdata = '0;
        f_raddr = bkt_reg;
        t_we    = 1'b0;
        c_we    = 1'b0;
        e_waddr = {bkt_reg, idx_reg[EW-1:0]};
        e_raddr = {bkt_reg, idx_reg[EW-1:0]};
        t_wdata = tag_reg;
        c_wdata = cost_reg;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                f_we = 1'b1;
            end
            S_CMP:
            begin
                c_we    = (t_rdata == tag_reg) && (type_reg == REQ_ADD)
                          && !(better_reg && dup_reg) && is_better;
                e_waddr = {bkt_reg, idx_reg[EW-1:0]};
            end
            S_APPEND:
            begin
                t_we    = 1'b1;
                c_we    = 1'b1;
                e_waddr = {bkt_reg, fill_reg[EW-1:0]};
                f_we    = 1'b1;
                f_wdata = fill_reg + FW'(1);
            end
            S_SHWR:
            begin
                t_we    = 1'b1;
                c_we    = 1'b1;
                e_waddr = {bkt_reg, EW'(idx_reg - FW'(1))};
                t_wdata = t_rdata;
                c_wdata = c_rdata;
            end
            S_DONE:
            begin
                f_we    = (type_reg == REQ_REMOVE);
                f_wdata = fill_reg - FW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            eps_reg       <= 16'd1;
            total_reg     <= '0;
            bkt_reg       <= '0;
            tag_reg       <= '0;
            cost_reg      <= '0;
            type_reg      <= '0;
            fill_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            better_reg    <= 1'b0;
            dup_reg       <= 1'b0;
            rem_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            if (cost_epsilon_we)
            begin
                eps_reg <= cost_epsilon_wdata;
            end
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    bkt_reg <= bkt_reg + BW'(1);
                    if (bkt_reg == BW'(BUCKETS - 1))
                    begin
                        if (state_reg == S_CLEAR)
                        begin
                            total_reg             <= '0;
                            rsp_reg.status        <= ST_CLEARED;
                            rsp_reg.unique_count  <= '0;
                            rsp_valid_reg         <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        type_reg   <= req.req_type;
                        tag_reg    <= req.entry_tag;
                        cost_reg   <= req_cost;
                        better_reg <= 1'b0;
                        dup_reg    <= 1'b0;
                        idx_reg    <= '0;
                        if (req.req_type == REQ_CLEAR)
                        begin
                            bkt_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else if (req.req_type == REQ_ADD || req.req_type == REQ_REMOVE)
                        begin
                            bkt_reg   <= req_bkt;
                            rem_reg   <= req.bucket_index;
                            step_reg  <= 4'((RSTEPS > 0) ? RSTEPS - 1 : 0);
                            state_reg <= (RSTEPS == 0) ? S_FREAD : S_REDUCE;
                        end
                        else
                        begin
                            rsp_reg.status       <= ST_NOTFOUND;
                            rsp_reg.unique_count <= total_reg;
                            rsp_valid_reg        <= 1'b1;
                        end
                    end
                end
                S_REDUCE:
                begin
                    rem_reg <= rem_sub;
                    if (step_reg == '0)
                    begin
                        bkt_reg   <= BW'(rem_sub);
                        state_reg <= S_FREAD;
                    end
                    else
                    begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                S_FREAD:
                begin
                    state_reg <= S_FWAIT;
                end
                S_FWAIT:
                begin
                    fill_reg <= f_rdata;
                    if (type_reg == REQ_ADD && f_rdata >= FW'(ENTRIES))
                    begin
                        rsp_reg.status       <= ST_FULL;
                        rsp_reg.unique_count <= total_reg;
                        rsp_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg >= fill_reg)
                    begin
                        if (type_reg == REQ_REMOVE)
                        begin
                            rsp_reg.status       <= ST_NOTFOUND;
                            rsp_reg.unique_count <= total_reg;
                            rsp_valid_reg        <= 1'b1;
                            state_reg            <= S_IDLE;
                        end
                        else if (better_reg && !dup_reg)
                        begin
                            rsp_reg.status       <= ST_BETTER;
                            rsp_reg.unique_count <= total_reg;
                            rsp_valid_reg        <= 1'b1;
                            state_reg            <= S_IDLE;
                        end
                        else if (dup_reg && !better_reg)
                        begin
                            rsp_reg.status       <= ST_DUPLICATE;
                            rsp_reg.unique_count <= total_reg;
                            rsp_valid_reg        <= 1'b1;
                            state_reg            <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_APPEND;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SWAIT;
                    end
                end
                S_SWAIT:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (t_rdata == tag_reg && type_reg == REQ_REMOVE)
                    begin
                        idx_reg   <= idx_reg + FW'(1);
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        if (t_rdata == tag_reg && !(better_reg && dup_reg))
                        begin
                            if (is_better)
                            begin
                                better_reg <= 1'b1;
                            end
                            else
                            begin
                                dup_reg <= 1'b1;
                            end
                        end
                        idx_reg   <= idx_reg + FW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_APPEND:
                begin
                    total_reg            <= total_reg + 14'd1;
                    rsp_reg.status       <= ST_ADDED;
                    rsp_reg.unique_count <= total_reg + 14'd1;
                    rsp_valid_reg        <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                S_SHIFT:
                begin
                    state_reg <= (idx_reg >= fill_reg) ? S_DONE : S_SHWAIT;
                end
                S_SHWAIT:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    idx_reg   <= idx_reg + FW'(1);
                    state_reg <= S_SHIFT;
                end
                S_DONE:
                begin
                    total_reg            <= (total_reg != '0) ? total_reg - 14'd1 : total_reg;
                    rsp_reg.status       <= ST_REMOVED;
                    rsp_reg.unique_count <= (total_reg != '0) ? total_reg - 14'd1 : total_reg;
                    rsp_valid_reg        <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
